FILE: rtl/core/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg: shared types for the saturating integer ALU core
// Opcodes, controller states and the controller/datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package sia_pkg;

	localparam int unsigned KIND_BITS = 4;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_MOD  = 4'd4,
		OP_POW  = 4'd5,
		OP_GCD  = 4'd6,
		OP_SUCC = 4'd7,
		OP_PRED = 4'd8,
		OP_EQ   = 4'd9,
		OP_NE   = 4'd10,
		OP_LT   = 4'd11,
		OP_LE   = 4'd12,
		OP_GT   = 4'd13
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV_STEP,
		ST_GCD_CHECK,
		ST_GCD_STEP,
		ST_POW_CHECK,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture operands
		logic simple;     // simple ops into result
		logic div_start;  // set up divider from a,b
		logic div_step;   // one restoring step
		logic div_fin;    // move quotient/remainder to result
		logic gcd_init;   // x=a, y=b
		logic gcd_div;    // start divider x % y
		logic gcd_swap;   // x=y, y=rem
		logic gcd_fin;    // result = x
		logic pow_init;   // acc=1, sq=a, e=b
		logic pow_mul;    // acc = sat(acc*sq)
		logic pow_sqr;    // sq = sat(sq*sq) unless e is one, e >>= 1
		logic pow_fin;    // result = acc
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;   // final divider step this cycle
		logic y_zero;     // gcd divisor is zero
		logic e_zero;     // exponent exhausted
		logic e_lsb;      // exponent low bit
		logic e_one;      // exponent equals one
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/sia_ctrl.sv
// ----------------------------------------------------------------------------
// sia_ctrl: sequencing controller
// Steps the datapath through division, gcd and power loops.
// ----------------------------------------------------------------------------
`default_nettype none
module sia_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [3:0]     kind,
	input  wire logic           res_taken,
	input  wire sia_pkg::sts_t  sts,
	output sia_pkg::cmd_t       cmd,
	output logic               busy,
	output logic               res_valid
);
	sia_pkg::state_t state_q, state_nx;
	logic [3:0] kind_q;
	logic gcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sia_pkg::ST_IDLE;
			kind_q  <= '0;
			gcd_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (start) kind_q <= kind;
			if (cmd.gcd_init) gcd_q <= 1'b1;
			else if (cmd.div_start) gcd_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sia_pkg::ST_IDLE: if (start) state_nx = sia_pkg::ST_DISPATCH;
			sia_pkg::ST_DISPATCH: begin
				case (kind_q)
					sia_pkg::OP_DIV, sia_pkg::OP_MOD: state_nx = sia_pkg::ST_DIV_STEP;
					sia_pkg::OP_GCD: state_nx = sia_pkg::ST_GCD_CHECK;
					sia_pkg::OP_POW: state_nx = sia_pkg::ST_POW_CHECK;
					default: state_nx = sia_pkg::ST_DONE;
				endcase
			end
			sia_pkg::ST_DIV_STEP: if (sts.div_last)
				state_nx = gcd_q ? sia_pkg::ST_GCD_CHECK : sia_pkg::ST_DONE;
			sia_pkg::ST_GCD_CHECK: state_nx = sts.y_zero ? sia_pkg::ST_DONE
				: sia_pkg::ST_DIV_STEP;
			sia_pkg::ST_POW_CHECK: begin
				if (sts.e_zero) state_nx = sia_pkg::ST_DONE;
				else if (sts.e_lsb) state_nx = sia_pkg::ST_POW_MUL;
				else state_nx = sia_pkg::ST_POW_SQR;
			end
			sia_pkg::ST_POW_MUL: state_nx = sia_pkg::ST_POW_SQR;
			sia_pkg::ST_POW_SQR: state_nx = sia_pkg::ST_POW_CHECK;
			sia_pkg::ST_DONE: if (res_taken) state_nx = sia_pkg::ST_IDLE;
			default: state_nx = sia_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			sia_pkg::ST_IDLE: cmd.load = start;
			sia_pkg::ST_DISPATCH: begin
				case (kind_q)
					sia_pkg::OP_DIV, sia_pkg::OP_MOD: cmd.div_start = 1'b1;
					sia_pkg::OP_GCD: cmd.gcd_init = 1'b1;
					sia_pkg::OP_POW: cmd.pow_init = 1'b1;
					default: cmd.simple = 1'b1;
				endcase
			end
			sia_pkg::ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					if (gcd_q) cmd.gcd_swap = 1'b1;
					else cmd.div_fin = 1'b1;
				end
			end
			sia_pkg::ST_GCD_CHECK: begin
				if (sts.y_zero) cmd.gcd_fin = 1'b1;
				else cmd.gcd_div = 1'b1;
			end
			sia_pkg::ST_POW_CHECK: if (sts.e_zero) cmd.pow_fin = 1'b1;
			sia_pkg::ST_POW_MUL: cmd.pow_mul = 1'b1;
			sia_pkg::ST_POW_SQR: cmd.pow_sqr = 1'b1;
			default: ;
		endcase
	end

	assign busy      = (state_q != sia_pkg::ST_IDLE);
	assign res_valid = (state_q == sia_pkg::ST_DONE);
endmodule
`default_nettype wire

FILE: rtl/core/sia_dp.sv
// ----------------------------------------------------------------------------
// sia_dp: ALU datapath
// Operand registers, restoring divider, saturating multiplier, result.
// ----------------------------------------------------------------------------
`default_nettype none
module sia_dp #(
	parameter int unsigned DATA_BITS = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [3:0]           kind,
	input  wire logic [14:0]          left_operand,
	input  wire logic [14:0]          right_operand,
	input  wire sia_pkg::cmd_t        cmd,
	output sia_pkg::sts_t             sts,
	output logic [14:0]               value
);
	localparam int unsigned W  = DATA_BITS;
	localparam int unsigned CW = $clog2(W + 1);
	localparam int unsigned FW = 15;

	logic [W-1:0] top;
	assign top = '1;

	// clamp field to range
	function automatic logic [W-1:0] clampf(input logic [FW-1:0] x);
		logic [W+FW-1:0] xe;
		logic [W+FW-1:0] te;
		begin
			xe = {{W{1'b0}}, x};
			te = {{FW{1'b0}}, {W{1'b1}}};
			clampf = (xe > te) ? {W{1'b1}} : xe[W-1:0];
		end
	endfunction

	logic [3:0]   kind_q;
	logic [W-1:0] a_q, b_q;
	logic [W-1:0] x_q, y_q;      // divider dividend / gcd x, divisor
	logic [W:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] acc_q, sq_q, e_q;
	logic [W-1:0] res_q;

	// restoring step
	logic [W:0] trial, diff;
	assign trial = {rem_q[W-1:0], x_q[W-1]};
	assign diff  = trial - {1'b0, y_q};

	// saturating multiply, shared for acc*sq and sq*sq
	logic [W-1:0] mop;
	logic [2*W-1:0] prod;
	logic [W-1:0] msat;
	assign mop  = cmd.pow_mul ? acc_q : sq_q;
	assign prod = mop * sq_q;
	assign msat = (prod[2*W-1:W] != '0) ? top : prod[W-1:0];

	// a*b for MUL: acc holds a, sq holds b after load
	logic [2*W-1:0] prod_ab;
	logic [W-1:0]   msat_ab;
	assign prod_ab = acc_q * sq_q;
	assign msat_ab = (prod_ab[2*W-1:W] != '0) ? top : prod_ab[W-1:0];

	// simple ops
	logic [W:0] sum, succ;
	logic [W-1:0] simple;
	always_comb begin
		sum  = {1'b0, a_q} + {1'b0, b_q};
		succ = {1'b0, a_q} + {{W{1'b0}}, 1'b1};
		case (kind_q)
			sia_pkg::OP_ADD:  simple = sum[W] ? top : sum[W-1:0];
			sia_pkg::OP_SUB:  simple = (a_q > b_q) ? a_q - b_q : '0;
			sia_pkg::OP_MUL:  simple = msat_ab;
			sia_pkg::OP_SUCC: simple = succ[W] ? top : succ[W-1:0];
			sia_pkg::OP_PRED: simple = (a_q != '0) ? a_q - 1'b1 : '0;
			sia_pkg::OP_EQ:   simple = {{(W-1){1'b0}}, a_q == b_q};
			sia_pkg::OP_NE:   simple = {{(W-1){1'b0}}, a_q != b_q};
			sia_pkg::OP_LT:   simple = {{(W-1){1'b0}}, a_q < b_q};
			sia_pkg::OP_LE:   simple = {{(W-1){1'b0}}, a_q <= b_q};
			sia_pkg::OP_GT:   simple = {{(W-1){1'b0}}, a_q > b_q};
			default:          simple = '0;
		endcase
	end

	// MUL reuses the load: acc holds a, sq holds b
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			a_q    <= '0;
			b_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			acc_q  <= '0;
			sq_q   <= '0;
			e_q    <= '0;
			res_q  <= '0;
		end else begin
			if (cmd.load) begin
				kind_q <= kind;
				a_q    <= clampf(left_operand);
				b_q    <= clampf(right_operand);
				sq_q   <= clampf(right_operand);
				acc_q  <= clampf(left_operand);
			end
			if (cmd.simple) res_q <= simple;
			if (cmd.div_start) begin
				x_q <= a_q; y_q <= b_q; rem_q <= '0; cnt_q <= '0;
			end
			if (cmd.gcd_init) begin
				x_q <= a_q; y_q <= b_q;
			end
			if (cmd.gcd_div) begin
				rem_q <= '0; cnt_q <= '0;
			end
			if (cmd.div_step) begin
				rem_q <= diff[W] ? trial : diff;
				x_q   <= {x_q[W-2:0], ~diff[W]};
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.gcd_swap) begin
				x_q <= y_q;
				y_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
			end
			if (cmd.div_fin) begin
				if (kind_q == sia_pkg::OP_DIV)
					res_q <= (y_q == '0) ? top : {x_q[W-2:0], ~diff[W]};
				else
					res_q <= (y_q == '0) ? a_q
						: (diff[W] ? trial[W-1:0] : diff[W-1:0]);
			end
			if (cmd.gcd_fin) res_q <= x_q;
			if (cmd.pow_init) begin
				acc_q <= {{(W-1){1'b0}}, 1'b1}; sq_q <= a_q; e_q <= b_q;
			end
			if (cmd.pow_mul) acc_q <= msat;
			if (cmd.pow_sqr) begin
				if (!sts.e_one) sq_q <= msat;
				e_q <= e_q >> 1;
			end
			if (cmd.pow_fin) res_q <= acc_q;
		end
	end

	assign sts.div_last = (cnt_q == CW'(W - 1));
	assign sts.y_zero   = (y_q == '0);
	assign sts.e_zero   = (e_q == '0);
	assign sts.e_lsb    = e_q[0];
	assign sts.e_one    = (e_q == {{(W-1){1'b0}}, 1'b1});

	generate
		if (W >= FW) begin : g_out_trunc
			assign value = res_q[FW-1:0];
		end else begin : g_out_ext
			assign value = {{(FW-W){1'b0}}, res_q};
		end
	endgenerate
endmodule
`default_nettype wire

FILE: rtl/core/saturating_integer_alu_core.sv
// ----------------------------------------------------------------------------
// saturating_integer_alu_core: saturating unsigned ALU
// Opcode plus two operands in, one clamped result out.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                     | tuser
// s_axis  | in  | left_operand[14:0], right_operand[29:15] | kind[3:0]
// m_axis  | out | value[14:0]                            | -
//
// Div/mod run a restoring divide, gcd repeats a divide per round, and power
// squares once per exponent bit, multiplying first when the bit is set.
// One item at a time; s_axis_tready is low from accept until the result
// beat is taken. m_axis stalls hold the result. arst_n clears all state.
// ----------------------------------------------------------------------------
`default_nettype none
module saturating_integer_alu_core #(
	parameter int unsigned DATA_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // left_operand, right_operand, pad
	input  wire logic [3:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // value, pad
);
	sia_pkg::cmd_t cmd;
	sia_pkg::sts_t sts;
	logic busy, res_valid, start;
	logic [14:0] value;

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;

	sia_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(s_axis_tuser),
		.res_taken(m_axis_tready), .sts(sts), .cmd(cmd),
		.busy(busy), .res_valid(res_valid)
	);

	sia_dp #(.DATA_BITS(DATA_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .kind(s_axis_tuser),
		.left_operand(s_axis_tdata[14:0]), .right_operand(s_axis_tdata[29:15]),
		.cmd(cmd), .sts(sts), .value(value)
	);

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {1'b0, value};
endmodule
`default_nettype wire

FILE: rtl/core/sia_chk.sv
// ----------------------------------------------------------------------------
// sia_chk: port checker
// Watches the core's stream ports for ordering slips, dropped results and a set pad bit.
// ----------------------------------------------------------------------------
`default_nettype none
module sia_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("ready after accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[15]) else $error("pad bit set");
endmodule

bind saturating_integer_alu_core sia_chk u_sia_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
